// ----- sv/btcm_pkg.sv -----
// Shared types, widths and helper functions for the block timestamp continuity monitor.
package btcm_pkg;

   localparam int SAMPLE_W    = 64;
   localparam int LENGTH_W    = 32;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 200;

   localparam logic [LENGTH_W-1:0] STALL_MAX = '1;

   typedef enum logic {
      CMD_BLOCK = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   // One accepted item, with the start-to-start difference already formed.
   typedef struct packed {
      cmd_type                     cmd;
      logic signed [SAMPLE_W-1:0]  block_start;
      logic [LENGTH_W-1:0]         block_length;
      logic                        time_valid;
      logic signed [SAMPLE_W-1:0]  start_diff;
      logic                        diff_ovf;
   } item_type;

   // Tracking state after the most recent item.
   typedef struct packed {
      logic                        seen_block;
      logic                        time_continuous;
      logic                        sum_overflowed;
      logic                        prev_time_valid;
      logic signed [SAMPLE_W-1:0]  prev_start;
      logic [LENGTH_W-1:0]         prev_length;
      logic signed [SAMPLE_W-1:0]  diff_sum;
      logic [LENGTH_W-1:0]         stall_count;
      logic [LENGTH_W-1:0]         max_length;
   } track_type;

   // Result item; the last member sits in the lowest bits.
   typedef struct packed {
      logic [LENGTH_W-1:0]         largest_block;
      logic [LENGTH_W-1:0]         stall_blocks;
      logic                        stall_valid;
      logic signed [SAMPLE_W-1:0]  continuous_samples;
      logic                        continuous_valid;
      logic signed [SAMPLE_W-1:0]  end_sample;
      logic                        end_valid;
   } result_type;

   // Signed overflow of s = a + b.
   function automatic logic add_ovf(input logic [SAMPLE_W-1:0] a,
                                    input logic [SAMPLE_W-1:0] b,
                                    input logic [SAMPLE_W-1:0] s);
      return ~(a[SAMPLE_W-1] ^ b[SAMPLE_W-1]) & (s[SAMPLE_W-1] ^ a[SAMPLE_W-1]);
   endfunction

endpackage

// ----- sv/btcm_intake.sv -----
// Input register stage: captures items and forms the start-to-start difference.
module btcm_intake
   import btcm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  cmd_type                    req_cmd,
   input  logic signed [SAMPLE_W-1:0] req_start,
   input  logic [LENGTH_W-1:0]        req_length,
   input  logic                       req_time_valid,
   input  logic                       item_take,
   output logic                       req_ready,
   output logic                       item_valid,
   output item_type                   item
);

   logic                       valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0] shadow_start_ff, shadow_start_in;
   item_type                   item_ff, item_in;
   logic                       accept;

   assign req_ready = !valid_ff || item_take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      item_in              = item_ff;
      item_in.cmd          = req_cmd;
      item_in.block_start  = req_start;
      item_in.block_length = req_length;
      item_in.time_valid   = req_time_valid;
      item_in.start_diff   = req_start - shadow_start_ff;
      item_in.diff_ovf     = (req_start[SAMPLE_W-1] ^ shadow_start_ff[SAMPLE_W-1])
                           & (item_in.start_diff[SAMPLE_W-1] ^ req_start[SAMPLE_W-1]);

      valid_in        = valid_ff;
      shadow_start_in = shadow_start_ff;
      if (accept) begin
         valid_in = 1'b1;
         // The shadow follows the start that the tracker will hold as its previous start.
         if (req_cmd == CMD_CLEAR) begin
            shadow_start_in = '0;
         end else begin
            shadow_start_in = req_start;
         end
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         shadow_start_ff <= '0;
      end else begin
         valid_ff        <= valid_in;
         shadow_start_ff <= shadow_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- sv/btcm_track.sv -----
// Tracking state: continuity, difference sum, stall count and largest block.
module btcm_track
   import btcm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      item_valid,
   input  item_type  item,
   input  logic      snap_take,
   output logic      item_take,
   output logic      snap_valid,
   output track_type state
);

   track_type                  state_ff, state_in;
   logic                       snap_valid_ff, snap_valid_in;
   logic signed [SAMPLE_W-1:0] next_sum;
   logic                       sum_ovf;
   logic                       stall_hit;
   logic                       tc_next;

   assign item_take = item_valid && (!snap_valid_ff || snap_take);

   assign next_sum  = state_ff.diff_sum + item.start_diff;
   assign sum_ovf   = add_ovf(state_ff.diff_sum, item.start_diff, next_sum);
   assign stall_hit = item.start_diff < $signed({{(SAMPLE_W-LENGTH_W){1'b0}},
                                                  state_ff.prev_length});
   assign tc_next   = state_ff.time_continuous && item.time_valid
                    && state_ff.prev_time_valid;

   always_comb begin
      state_in = state_ff;
      if (item.cmd == CMD_CLEAR) begin
         state_in                 = '0;
         state_in.time_continuous = 1'b1;
         state_in.max_length      = state_ff.max_length;
      end else begin
         if (item.block_length > state_ff.max_length) begin
            state_in.max_length = item.block_length;
         end
         if (!state_ff.seen_block) begin
            state_in.seen_block      = 1'b1;
            state_in.time_continuous = item.time_valid;
         end else begin
            state_in.time_continuous = tc_next;
            if (tc_next && !state_ff.sum_overflowed) begin
               if (item.diff_ovf || sum_ovf) begin
                  state_in.sum_overflowed = 1'b1;
               end else begin
                  state_in.diff_sum = next_sum;
                  if (stall_hit && state_ff.stall_count != STALL_MAX) begin
                     state_in.stall_count = state_ff.stall_count + LENGTH_W'(1);
                  end
               end
            end
         end
         state_in.prev_time_valid = item.time_valid;
         state_in.prev_start      = item.block_start;
         state_in.prev_length     = item.block_length;
      end

      snap_valid_in = snap_valid_ff;
      if (item_take) begin
         snap_valid_in = 1'b1;
      end else if (snap_take) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                 <= '0;
         state_ff.time_continuous <= 1'b1;
         snap_valid_ff            <= 1'b0;
      end else begin
         if (item_take) begin
            state_ff <= state_in;
         end
         snap_valid_ff <= snap_valid_in;
      end
   end

   assign state      = state_ff;
   assign snap_valid = snap_valid_ff;

`ifndef SYNTHESIS
   // A clear leaves no block seen and no stalls counted.
   assert property (@(posedge clock) disable iff (reset)
      (item_take && item.cmd == CMD_CLEAR) |=>
         (!state_ff.seen_block && state_ff.stall_count == '0))
      else $error("clear did not reset tracking state");

   // The largest block covers every block taken.
   assert property (@(posedge clock) disable iff (reset)
      (item_take && item.cmd == CMD_BLOCK) |=>
         (state_ff.max_length >= $past(item.block_length)))
      else $error("largest block below a taken block length");

   // Overflow stays set until a clear.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.sum_overflowed && !(item_take && item.cmd == CMD_CLEAR)) |=>
         state_ff.sum_overflowed)
      else $error("sum overflow flag dropped without clear");

   // Stalls are only counted after a block was seen.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.stall_count != '0) |-> state_ff.seen_block)
      else $error("stall count without a seen block");
`endif

endmodule

// ----- sv/btcm_snap.sv -----
// Result register: snapshot of end sample, continuous length, stall count and largest block.
module btcm_snap
   import btcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       snap_valid,
   input  track_type  state,
   input  logic       rsp_ready,
   output logic       snap_take,
   output logic       rsp_valid,
   output result_type result
);

   logic                       valid_ff, valid_in;
   result_type                 result_ff, result_in;
   logic [SAMPLE_W-1:0]        len_ext;
   logic signed [SAMPLE_W-1:0] end_sum;
   logic signed [SAMPLE_W-1:0] cont_sum;
   logic                       end_ok;
   logic                       cont_ok;

   assign snap_take = snap_valid && (!valid_ff || rsp_ready);

   assign len_ext  = {{(SAMPLE_W-LENGTH_W){1'b0}}, state.prev_length};
   assign end_sum  = state.prev_start + len_ext;
   assign cont_sum = state.diff_sum + len_ext;
   assign end_ok   = state.seen_block && state.prev_time_valid
                   && !add_ovf(state.prev_start, len_ext, end_sum);
   assign cont_ok  = state.seen_block && state.time_continuous && !state.sum_overflowed
                   && !add_ovf(state.diff_sum, len_ext, cont_sum);

   always_comb begin
      result_in.end_valid          = end_ok;
      result_in.end_sample         = end_ok ? end_sum : '0;
      result_in.continuous_valid   = cont_ok;
      result_in.continuous_samples = cont_ok ? cont_sum : '0;
      result_in.stall_valid        = state.seen_block;
      result_in.stall_blocks       = state.seen_block ? state.stall_count : '0;
      result_in.largest_block      = state.max_length;

      valid_in = valid_ff;
      if (snap_take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

endmodule

// ----- sv/block_timestamp_continuity_monitor.sv -----
// Top level of the block timestamp continuity monitor.
//
// Each item on the req_ stream is either an audio block descriptor (start
// sample, length, timestamp-valid flag) or a clear command, selected by
// req_tuser. For every item the monitor returns one snapshot item on the
// rsp_ stream: end sample, continuous material length, stall count and the
// largest block length, each with its valid flag where it has one.
// The monitor has three register stages: an input register that also forms
// the start-to-start difference, the tracking state, and the result register.
// A result reaches the result register after its item has passed the input
// register and the tracking state; one item per cycle is sustained while
// rsp_tready is high.
// Clear resets all tracking except the largest block length, which only the
// synchronous reset clears. After reset no result is pending and req_tready
// is high. When the receiver holds rsp_tready low, up to three items are
// buffered in the stages before req_tready drops; nothing is lost or repeated.
module block_timestamp_continuity_monitor
   import btcm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [63:0] block_start, [95:64] block_length, [96] time_valid, [103:97] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] end_valid, [64:1] end_sample, [65] continuous_valid,
   // [129:66] continuous_samples, [130] stall_valid, [162:131] stall_blocks,
   // [194:163] largest_block, [199:195] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   item_type   item;
   track_type  state;
   result_type result;
   logic       item_valid;
   logic       item_take;
   logic       snap_valid;
   logic       snap_take;

   btcm_intake u_intake (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_cmd        (cmd_type'(req_tuser)),
      .req_start      (req_tdata[SAMPLE_W-1:0]),
      .req_length     (req_tdata[SAMPLE_W+LENGTH_W-1:SAMPLE_W]),
      .req_time_valid (req_tdata[SAMPLE_W+LENGTH_W]),
      .item_take      (item_take),
      .req_ready      (req_tready),
      .item_valid     (item_valid),
      .item           (item)
   );

   btcm_track u_track (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .snap_take  (snap_take),
      .item_take  (item_take),
      .snap_valid (snap_valid),
      .state      (state)
   );

   btcm_snap u_snap (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .state      (state),
      .rsp_ready  (rsp_tready),
      .snap_take  (snap_take),
      .rsp_valid  (rsp_tvalid),
      .result     (result)
   );

   // The result struct is laid out with end_valid in its lowest bit.
   assign rsp_tdata = {{(RSP_TDATA_W-$bits(result_type)){1'b0}}, result};

endmodule
